@@ hw/rtl/gfi_pkg.sv @@
`timescale 1ns / 1ps
package gfi_pkg;

    localparam int MAX_NODES = 65536;
    localparam int NODE_AW   = $clog2(MAX_NODES);
    localparam int MAX_AXIS  = 1024;
    localparam int AXIS_W    = $clog2(MAX_AXIS);
    localparam int SIZE_W    = 11;
    localparam int DATA_W    = 32;
    localparam int CFG_AW    = 3;
    localparam int MUL_AW    = 33;
    localparam int MUL_BW    = 25;
    localparam int MUL_PW    = MUL_AW + MUL_BW;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } t_cmd;

    typedef enum logic [CFG_AW-1:0] {
        REG_MODE        = 3'd0,
        REG_SIZE_X      = 3'd1,
        REG_SIZE_Y      = 3'd2,
        REG_SIZE_Z      = 3'd3,
        REG_ORIGIN_X    = 3'd4,
        REG_ORIGIN_Y    = 3'd5,
        REG_ORIGIN_Z    = 3'd6,
        REG_INV_SPACING = 3'd7
    } t_reg;

    localparam logic [1:0] MODE_1D = 2'd0;
    localparam logic [1:0] MODE_2D = 2'd1;

    typedef struct packed {
        t_cmd                      command;
        logic [NODE_AW-1:0]        node_index;
        logic signed [DATA_W-1:0]  node_value;
        logic signed [DATA_W-1:0]  pos_x;
        logic signed [DATA_W-1:0]  pos_y;
        logic signed [DATA_W-1:0]  pos_z;
    } t_item;

    typedef struct packed {
        logic signed [DATA_W-1:0]  potential;
        logic                      saturated;
    } t_result;

endpackage

@@ hw/rtl/gfi_ram.sv @@
`timescale 1ns / 1ps
module gfi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/gfi_mul.sv @@
`timescale 1ns / 1ps
module gfi_mul (
    input  logic                          i_clk,
    input  logic [gfi_pkg::MUL_AW-1:0]    i_a,
    input  logic [gfi_pkg::MUL_BW-1:0]    i_b,
    output logic [gfi_pkg::MUL_PW-1:0]    o_p
);

    logic [gfi_pkg::MUL_PW-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= gfi_pkg::MUL_PW'(i_a) * gfi_pkg::MUL_PW'(i_b);
    end

    assign o_p = r_p;

endmodule

@@ hw/rtl/grid_field_interpolator.sv @@
`timescale 1ns / 1ps
// Channel   | Direction | Handshake                     | Word
// ----------+-----------+-------------------------------+------------------
// item      | in        | start && !busy                | i_item (t_item)
// result    | out       | o_result_strobe, one cycle    | o_result (t_result)
// config    | in        | i_cfg_valid && o_cfg_ready    | i_cfg_index, i_cfg_data
//
// A load is written to the node memory without raising busy; a query before any load answers in the next cycle.
// A query keeps busy high while it works through the axes, the corner address, the corner reads and the blends,
// in that order, set by the single shared 33x25 multiplier and the single node memory port.
// Reset is synchronous and active low; it clears the control state and sets the config registers to defaults.
// The receiver cannot stall, so each result word is shown for exactly one cycle.
module grid_field_interpolator (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  gfi_pkg::t_item               i_item,
    output gfi_pkg::t_result             o_result,
    output logic                         o_result_strobe,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [gfi_pkg::CFG_AW-1:0]   i_cfg_index,
    input  logic [31:0]                  i_cfg_data
);

    typedef enum logic [14:0] {
        S_IDLE = 15'b000000000000001,
        S_AXD  = 15'b000000000000010,
        S_AXM0 = 15'b000000000000100,
        S_AXM1 = 15'b000000000001000,
        S_AXS  = 15'b000000000010000,
        S_AXF  = 15'b000000000100000,
        S_AD0  = 15'b000000001000000,
        S_AD1  = 15'b000000010000000,
        S_AD2  = 15'b000000100000000,
        S_AD3  = 15'b000001000000000,
        S_RD   = 15'b000010000000000,
        S_LH   = 15'b000100000000000,
        S_LM0  = 15'b001000000000000,
        S_LM1  = 15'b010000000000000,
        S_LF   = 15'b100000000000000
    } t_state;

    localparam logic [41:0] TERM_CAP = 42'h200_0000_0000;

    function automatic logic [gfi_pkg::SIZE_W-1:0] eff_size(
        input logic [gfi_pkg::SIZE_W-1:0] s);
        if (s < gfi_pkg::SIZE_W'(2)) begin
            return gfi_pkg::SIZE_W'(2);
        end else if (s > gfi_pkg::SIZE_W'(gfi_pkg::MAX_AXIS)) begin
            return gfi_pkg::SIZE_W'(gfi_pkg::MAX_AXIS);
        end
        return s;
    endfunction

    t_state                              r_state, n_state;
    logic [1:0]                          r_mode;
    logic [gfi_pkg::SIZE_W-1:0]          r_size_x, r_size_y, r_size_z;
    logic [31:0]                         r_org_x, r_org_y, r_org_z, r_inv;
    logic                                r_present;
    logic                                r_out_v;
    gfi_pkg::t_result                    r_out;
    logic [1:0]                          r_ax, r_na;
    logic [3:0]                          r_nc;
    logic [31:0]                         r_px, r_py, r_pz;
    logic [31:0]                         r_mag;
    logic                                r_aneg;
    logic [47:0]                         r_acc;
    logic [63:0]                         r_prod;
    logic [gfi_pkg::AXIS_W-1:0]          r_ci, r_cj, r_ck;
    logic [49:0]                         r_tt, r_tu, r_tv;
    logic [gfi_pkg::NODE_AW-1:0]         r_base, r_sxy;
    logic [3:0]                          r_rc, r_qn;
    logic                                r_rdv;
    logic [31:0]                         r_q [0:7];
    logic [31:0]                         r_la;
    logic [32:0]                         r_dm;
    logic [48:0]                         r_tm;
    logic                                r_lneg;
    logic [gfi_pkg::MUL_PW-1:0]          r_hi;
    logic [2:0]                          r_lc;
    logic                                r_sat;

    logic                                accept, is_query;
    logic [gfi_pkg::SIZE_W-1:0]          sx, sy;
    logic [gfi_pkg::NODE_AW-1:0]         sx16;
    logic [31:0]                         pos_sel, org_sel;
    logic [gfi_pkg::SIZE_W-1:0]          size_sel;
    logic [gfi_pkg::AXIS_W-1:0]          lim;
    logic [32:0]                         d, d_abs;
    logic [gfi_pkg::MUL_AW-1:0]          mul_a;
    logic [gfi_pkg::MUL_BW-1:0]          mul_b;
    logic [gfi_pkg::MUL_PW-1:0]          mp;
    logic [31:0]                         iraw;
    logic [gfi_pkg::AXIS_W-1:0]          ipos, f_idx;
    logic [49:0]                         tpos, tneg, f_t;
    logic [48:0]                         qmag;
    logic [3:0]                          half, quarter;
    logic [49:0]                         tsel, tabs;
    logic [32:0]                         diff, dabs;
    logic                                cap;
    logic [41:0]                         m_raw, m;
    logic [43:0]                         sm, lsum;
    logic                                sat_hi, sat_lo, lsat;
    logic [31:0]                         lres;
    logic [2:0]                          corner;
    logic [gfi_pkg::NODE_AW-1:0]         caddr, ram_addr;
    logic [31:0]                         rdata;
    logic                                ram_we, last_lerp;

    assign accept      = start && !busy;
    assign is_query    = (i_item.command == gfi_pkg::CMD_QUERY);
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_result    = r_out;
    assign o_result_strobe = r_out_v;

    assign sx   = eff_size(r_size_x);
    assign sy   = eff_size(r_size_y);
    assign sx16 = gfi_pkg::NODE_AW'(sx);

    always_comb begin
        case (r_ax)
            2'd0: begin
                pos_sel  = r_px;
                org_sel  = r_org_x;
                size_sel = r_size_x;
            end
            2'd1: begin
                pos_sel  = r_py;
                org_sel  = r_org_y;
                size_sel = r_size_y;
            end
            default: begin
                pos_sel  = r_pz;
                org_sel  = r_org_z;
                size_sel = r_size_z;
            end
        endcase
    end

    assign lim   = gfi_pkg::AXIS_W'(eff_size(size_sel) - gfi_pkg::SIZE_W'(2));
    assign d     = {pos_sel[31], pos_sel} - {org_sel[31], org_sel};
    assign d_abs = d[32] ? -d : d;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_AXM0: begin
                mul_a = {1'b0, r_mag};
                mul_b = gfi_pkg::MUL_BW'(r_inv[15:0]);
            end
            S_AXM1: begin
                mul_a = {1'b0, r_mag};
                mul_b = gfi_pkg::MUL_BW'(r_inv[31:16]);
            end
            S_AD0: begin
                mul_a = gfi_pkg::MUL_AW'(r_ck);
                mul_b = gfi_pkg::MUL_BW'(sy);
            end
            S_AD1: begin
                mul_a = gfi_pkg::MUL_AW'(mp[gfi_pkg::NODE_AW-1:0]
                        + gfi_pkg::NODE_AW'(r_cj));
                mul_b = gfi_pkg::MUL_BW'(sx);
            end
            S_AD2: begin
                mul_a = gfi_pkg::MUL_AW'(sy);
                mul_b = gfi_pkg::MUL_BW'(sx);
            end
            S_LM0: begin
                mul_a = r_dm;
                mul_b = r_tm[48:24];
            end
            S_LM1: begin
                mul_a = r_dm;
                mul_b = {1'b0, r_tm[23:0]};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    gfi_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mp)
    );

    assign iraw  = r_prod[63:32];
    assign ipos  = (iraw > 32'(lim)) ? lim : iraw[gfi_pkg::AXIS_W-1:0];
    assign tpos  = {2'b00, r_prod[63:16]} - {24'd0, ipos, 16'd0};
    assign qmag  = {1'b0, r_prod[63:16]} + 49'(|r_prod[15:0]);
    assign tneg  = -{1'b0, qmag};
    assign f_idx = r_aneg ? '0 : ipos;
    assign f_t   = r_aneg ? tneg : tpos;

    assign half    = r_nc >> 1;
    assign quarter = r_nc >> 2;

    always_comb begin
        if ({1'b0, r_lc} < half) begin
            tsel = r_tt;
        end else if ({1'b0, r_lc} < half + quarter) begin
            tsel = r_tu;
        end else begin
            tsel = r_tv;
        end
    end

    assign tabs = tsel[49] ? -tsel : tsel;
    assign diff = {r_q[1][31], r_q[1]} - {r_q[0][31], r_q[0]};
    assign dabs = diff[32] ? -diff : diff;

    assign cap    = |r_hi[57:32];
    assign m_raw  = 42'({r_hi[31:0], 8'd0}) + 42'(mp[56:16]);
    assign m      = (cap || (m_raw > TERM_CAP)) ? TERM_CAP : m_raw;
    assign sm     = r_lneg ? -{2'b00, m} : {2'b00, m};
    assign lsum   = {{12{r_la[31]}}, r_la} + sm;
    assign sat_hi = !lsum[43] && (lsum[42:31] != 12'h000);
    assign sat_lo = lsum[43] && (lsum[42:31] != 12'hFFF);
    assign lsat   = sat_hi || sat_lo;
    assign lres   = sat_hi ? 32'h7FFF_FFFF : (sat_lo ? 32'h8000_0000 : lsum[31:0]);
    assign last_lerp = (4'(r_lc) == r_nc - 4'd2);

    assign corner = r_rc[2:0];
    assign caddr  = r_base + (corner[0] ? gfi_pkg::NODE_AW'(1) : '0)
                  + (corner[1] ? sx16 : '0) + (corner[2] ? r_sxy : '0);
    assign ram_addr = (r_state == S_RD) ? caddr : i_item.node_index;
    assign ram_we   = accept && !is_query;

    gfi_ram #(
        .WIDTH (gfi_pkg::DATA_W),
        .DEPTH (gfi_pkg::MAX_NODES)
    ) u_nodes (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (i_item.node_value),
        .o_rdata (rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && is_query && r_present) begin
                    n_state = S_AXD;
                end
            end
            S_AXD:  n_state = S_AXM0;
            S_AXM0: n_state = S_AXM1;
            S_AXM1: n_state = S_AXS;
            S_AXS:  n_state = S_AXF;
            S_AXF: begin
                n_state = (r_ax == r_na - 2'd1) ? S_AD0 : S_AXD;
            end
            S_AD0:  n_state = S_AD1;
            S_AD1:  n_state = S_AD2;
            S_AD2:  n_state = S_AD3;
            S_AD3:  n_state = S_RD;
            S_RD: begin
                if ((r_rc == r_nc) && !r_rdv) begin
                    n_state = S_LH;
                end
            end
            S_LH:   n_state = S_LM0;
            S_LM0:  n_state = S_LM1;
            S_LM1:  n_state = S_LF;
            S_LF: begin
                n_state = last_lerp ? S_IDLE : S_LH;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_present <= 1'b0;
            r_out_v   <= 1'b0;
            r_mode    <= 2'd2;
            r_size_x  <= gfi_pkg::SIZE_W'(2);
            r_size_y  <= gfi_pkg::SIZE_W'(2);
            r_size_z  <= gfi_pkg::SIZE_W'(2);
            r_org_x   <= '0;
            r_org_y   <= '0;
            r_org_z   <= '0;
            r_inv     <= 32'h0001_0000;
        end else begin
            r_state <= n_state;
            r_out_v <= (accept && is_query && !r_present)
                    || ((r_state == S_LF) && last_lerp);
            if (ram_we) begin
                r_present <= 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (gfi_pkg::t_reg'(i_cfg_index))
                    gfi_pkg::REG_MODE:        r_mode   <= i_cfg_data[1:0];
                    gfi_pkg::REG_SIZE_X:      r_size_x <= i_cfg_data[gfi_pkg::SIZE_W-1:0];
                    gfi_pkg::REG_SIZE_Y:      r_size_y <= i_cfg_data[gfi_pkg::SIZE_W-1:0];
                    gfi_pkg::REG_SIZE_Z:      r_size_z <= i_cfg_data[gfi_pkg::SIZE_W-1:0];
                    gfi_pkg::REG_ORIGIN_X:    r_org_x  <= i_cfg_data;
                    gfi_pkg::REG_ORIGIN_Y:    r_org_y  <= i_cfg_data;
                    gfi_pkg::REG_ORIGIN_Z:    r_org_z  <= i_cfg_data;
                    gfi_pkg::REG_INV_SPACING: r_inv    <= i_cfg_data;
                    default:                  r_mode   <= r_mode;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (accept && is_query) begin
                    r_px  <= i_item.pos_x;
                    r_py  <= i_item.pos_y;
                    r_pz  <= i_item.pos_z;
                    r_ax  <= 2'd0;
                    r_ci  <= '0;
                    r_cj  <= '0;
                    r_ck  <= '0;
                    r_tt  <= '0;
                    r_tu  <= '0;
                    r_tv  <= '0;
                    r_sat <= 1'b0;
                    r_lc  <= '0;
                    r_qn  <= '0;
                    r_rc  <= '0;
                    r_rdv <= 1'b0;
                    r_out <= '0;
                    case (r_mode)
                        gfi_pkg::MODE_1D: begin
                            r_na <= 2'd1;
                            r_nc <= 4'd2;
                        end
                        gfi_pkg::MODE_2D: begin
                            r_na <= 2'd2;
                            r_nc <= 4'd4;
                        end
                        default: begin
                            r_na <= 2'd3;
                            r_nc <= 4'd8;
                        end
                    endcase
                end
            end
            S_AXD: begin
                r_mag  <= d_abs[31:0];
                r_aneg <= d[32];
            end
            S_AXM1: r_acc  <= mp[47:0];
            S_AXS:  r_prod <= 64'(r_acc) + {mp[47:0], 16'd0};
            S_AXF: begin
                case (r_ax)
                    2'd0: begin
                        r_ci <= f_idx;
                        r_tt <= f_t;
                    end
                    2'd1: begin
                        r_cj <= f_idx;
                        r_tu <= f_t;
                    end
                    default: begin
                        r_ck <= f_idx;
                        r_tv <= f_t;
                    end
                endcase
                r_ax <= r_ax + 2'd1;
            end
            S_AD2: r_base <= mp[gfi_pkg::NODE_AW-1:0] + gfi_pkg::NODE_AW'(r_ci);
            S_AD3: r_sxy  <= mp[gfi_pkg::NODE_AW-1:0];
            S_RD: begin
                if (r_rc != r_nc) begin
                    r_rc  <= r_rc + 4'd1;
                    r_rdv <= 1'b1;
                end else begin
                    r_rdv <= 1'b0;
                end
                if (r_rdv) begin
                    r_q[r_qn[2:0]] <= rdata;
                    r_qn           <= r_qn + 4'd1;
                end
            end
            S_LH: begin
                r_la   <= r_q[0];
                r_dm   <= dabs;
                r_tm   <= tabs[48:0];
                r_lneg <= tsel[49] ^ diff[32];
                for (int n = 0; n < 6; n++) begin
                    r_q[n] <= r_q[n + 2];
                end
                r_qn <= r_qn - 4'd2;
            end
            S_LM1: r_hi <= mp;
            S_LF: begin
                r_q[r_qn[2:0]] <= lres;
                r_qn  <= r_qn + 4'd1;
                r_lc  <= r_lc + 3'd1;
                r_sat <= r_sat || lsat;
                if (last_lerp) begin
                    r_out.potential <= lres;
                    r_out.saturated <= r_sat || lsat;
                end
            end
            default: r_lc <= r_lc;
        endcase
    end

endmodule

@@ hw/rtl/gfi_checker.sv @@
`timescale 1ns / 1ps
module gfi_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input gfi_pkg::t_item               i_item,
    input gfi_pkg::t_result             o_result,
    input logic                         o_result_strobe
);

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy && !o_result_strobe)
        else $error("block not idle after reset");

    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_item.command == gfi_pkg::CMD_LOAD) |=> !o_result_strobe)
        else $error("load produced a result word");

    a_query_acts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_item.command == gfi_pkg::CMD_QUERY)
        |=> busy || o_result_strobe)
        else $error("query neither started nor answered");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> !busy)
        else $error("result word shown while still busy");

    a_load_no_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe && $past(start && !busy) |-> !o_result.saturated)
        else $error("empty field answer flagged as saturated");

endmodule

bind grid_field_interpolator gfi_checker u_gfi_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .i_item          (i_item),
    .o_result        (o_result),
    .o_result_strobe (o_result_strobe)
);

@@ tb/tb_grid_field_interpolator.sv @@
`timescale 1ns / 1ps
module tb_grid_field_interpolator;

    localparam logic [1:0] MODE_3D  = 2'd2;
    localparam logic [1:0] MODE_3X  = 2'd3;
    localparam int         CYC_MAX  = 3000000;
    localparam int         SETTLE   = 100;
    localparam int         RND_ITEMS = 60;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           start = 1'b0;
    logic           busy;
    gfi_pkg::t_item   i_item = '0;
    gfi_pkg::t_result o_result;
    logic           o_result_strobe;
    logic           i_cfg_valid = 1'b0;
    logic           o_cfg_ready;
    logic [gfi_pkg::CFG_AW-1:0] i_cfg_index = '0;
    logic [31:0]    i_cfg_data = '0;

    grid_field_interpolator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .o_result(o_result), .o_result_strobe(o_result_strobe),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Shadow of the block's registers and node store.
    logic [1:0]  g_mode = MODE_3D;
    logic [10:0] g_sx = 11'd2, g_sy = 11'd2, g_sz = 11'd2;
    logic [31:0] g_ox = '0, g_oy = '0, g_oz = '0, g_inv = 32'd65536;
    logic signed [31:0] node_mem [gfi_pkg::MAX_NODES];
    bit          node_written [gfi_pkg::MAX_NODES];
    bit          field_loaded = 1'b0;

    gfi_pkg::t_result pending_results [$];
    int          errors = 0, n_loads = 0, n_queries = 0, n_sat = 0, n_phases = 0;
    int          cycles = 0;
    bit          calm = 1'b0;

    function automatic int unsigned axis_nodes(logic [10:0] s);
        if (s < 2) return 2;
        if (s > gfi_pkg::MAX_AXIS) return gfi_pkg::MAX_AXIS;
        return s;
    endfunction

    function automatic void locate_cell(input logic [31:0] pos, input logic [31:0] org,
                                        input logic [10:0] sz,
                                        output longint unsigned idx, output longint frac);
        longint d, g;
        logic [63:0] mag, prod;
        longint unsigned lim;
        d = longint'($signed(pos)) - longint'($signed(org));
        mag = (d < 0) ? -d : d;
        prod = mag * {32'd0, g_inv};
        lim = axis_nodes(sz) - 2;
        if (d >= 0) begin
            g = longint'(prod >> 16);
            idx = prod >> 32;
        end else begin
            g = -longint'((prod >> 16) + (prod[15:0] != 16'd0));
            idx = 0;
        end
        if (idx > lim) idx = lim;
        frac = g - longint'(idx << 16);
    endfunction

    function automatic longint scaled_diff(longint t, longint diff);
        logic [63:0] tm, dm, th, tl, hi, m;
        bit neg;
        neg = (t < 0) != (diff < 0);
        tm = (t < 0) ? -t : t;
        dm = (diff < 0) ? -diff : diff;
        th = tm >> 24;
        tl = tm & 64'hFFFFFF;
        hi = th * dm;
        if (hi >= 64'h1_0000_0000) begin
            m = 64'd1 << 41;
        end else begin
            m = (hi << 8) + ((tl * dm) >> 16);
            if (m > (64'd1 << 41)) m = 64'd1 << 41;
        end
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic logic signed [31:0] blend(logic signed [31:0] a, logic signed [31:0] b,
                                                 longint t, inout bit sat);
        longint r;
        r = longint'(a) + scaled_diff(t, longint'(b) - longint'(a));
        if (r > 64'sd2147483647) begin
            sat = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (r < -64'sd2147483648) begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return r[31:0];
    endfunction

    // Corner addresses in the order x, then y, then z; returns the corner count.
    function automatic int cell_corners(gfi_pkg::t_item it, output logic [15:0] addr [8],
                                        output longint t, output longint u, output longint v);
        longint unsigned i, j, k, sx, sy, ii, jj, kk;
        int n;
        sx = axis_nodes(g_sx);
        sy = axis_nodes(g_sy);
        j = 0; k = 0; u = 0; v = 0;
        locate_cell(it.pos_x, g_ox, g_sx, i, t);
        if (g_mode != gfi_pkg::MODE_1D) locate_cell(it.pos_y, g_oy, g_sy, j, u);
        if (g_mode != gfi_pkg::MODE_1D && g_mode != gfi_pkg::MODE_2D)
            locate_cell(it.pos_z, g_oz, g_sz, k, v);
        n = (g_mode == gfi_pkg::MODE_1D) ? 2 : (g_mode == gfi_pkg::MODE_2D) ? 4 : 8;
        for (int c = 0; c < 8; c++) begin
            ii = i + longint'(c & 1);
            jj = j + longint'((c >> 1) & 1);
            kk = k + longint'((c >> 2) & 1);
            addr[c] = 16'(((kk * sy + jj) * sx + ii) % gfi_pkg::MAX_NODES);
        end
        return n;
    endfunction

    function automatic gfi_pkg::t_result field_at(gfi_pkg::t_item it);
        logic [15:0] addr [8];
        logic signed [31:0] s [8];
        logic signed [31:0] a0, a1, b0, b1, p0, p1;
        longint t, u, v;
        int n;
        bit sat;
        gfi_pkg::t_result r;
        sat = 1'b0;
        if (!field_loaded) return '0;
        n = cell_corners(it, addr, t, u, v);
        for (int c = 0; c < 8; c++) s[c] = node_mem[addr[c]];
        if (n == 2) begin
            r.potential = blend(s[0], s[1], t, sat);
        end else if (n == 4) begin
            a0 = blend(s[0], s[1], t, sat);
            a1 = blend(s[2], s[3], t, sat);
            r.potential = blend(a0, a1, u, sat);
        end else begin
            a0 = blend(s[0], s[1], t, sat);
            a1 = blend(s[2], s[3], t, sat);
            b0 = blend(s[4], s[5], t, sat);
            b1 = blend(s[6], s[7], t, sat);
            p0 = blend(a0, a1, u, sat);
            p1 = blend(b0, b1, u, sat);
            r.potential = blend(p0, p1, v, sat);
        end
        r.saturated = sat;
        return r;
    endfunction

    always @(posedge i_clk) begin
        gfi_pkg::t_result want;
        if (i_rst_n && o_result_strobe) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word potential=%h sat=%b",
                         $time, o_result.potential, o_result.saturated);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (o_result.potential !== want.potential) begin
                    $display("%0t: potential expected %h actual %h",
                             $time, want.potential, o_result.potential);
                    errors++;
                end
                if (o_result.saturated !== want.saturated) begin
                    $display("%0t: saturated expected %b actual %b",
                             $time, want.saturated, o_result.saturated);
                    errors++;
                end
                if (want.saturated) n_sat++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYC_MAX) begin
            $display("Timed out after %0d cycles.", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Called at a falling edge; returns at a falling edge once the word is taken.
    task automatic send_item(gfi_pkg::t_item it, bit typed, gfi_pkg::t_result typed_res);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 12);
        repeat (gap) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        if (it.command == gfi_pkg::CMD_LOAD) begin
            node_mem[it.node_index] = it.node_value;
            node_written[it.node_index] = 1'b1;
            field_loaded = 1'b1;
            n_loads++;
        end else begin
            pending_results.push_back(typed ? typed_res : field_at(it));
            n_queries++;
        end
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] node_sample();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 85) return $urandom_range(0, 32'h1F_FFFF) - 32'h10_0000;
        if (pick < 95) return $urandom;
        return pick[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
    endfunction

    task automatic load_node(logic [15:0] idx, logic [31:0] val);
        gfi_pkg::t_item it;
        it = '0;
        it.command = gfi_pkg::CMD_LOAD;
        it.node_index = idx;
        it.node_value = val;
        it.pos_x = $urandom;
        it.pos_y = $urandom;
        it.pos_z = $urandom;
        send_item(it, 1'b0, '0);
    endtask

    // A query never reads a node that was not loaded first.
    task automatic query_point(gfi_pkg::t_item it);
        logic [15:0] addr [8];
        longint t, u, v;
        int n;
        if (field_loaded) begin
            n = cell_corners(it, addr, t, u, v);
            for (int c = 0; c < n; c++)
                if (!node_written[addr[c]]) load_node(addr[c], node_sample());
        end
        send_item(it, 1'b0, '0);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        while (busy) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(gfi_pkg::t_reg idx, logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        case (idx)
            gfi_pkg::REG_MODE:        g_mode = val[1:0];
            gfi_pkg::REG_SIZE_X:      g_sx = val[10:0];
            gfi_pkg::REG_SIZE_Y:      g_sy = val[10:0];
            gfi_pkg::REG_SIZE_Z:      g_sz = val[10:0];
            gfi_pkg::REG_ORIGIN_X:    g_ox = val;
            gfi_pkg::REG_ORIGIN_Y:    g_oy = val;
            gfi_pkg::REG_ORIGIN_Z:    g_oz = val;
            gfi_pkg::REG_INV_SPACING: g_inv = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_grid(logic [1:0] m, logic [10:0] sx, logic [10:0] sy, logic [10:0] sz,
                            logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                            logic [31:0] inv);
        drain();
        write_reg(gfi_pkg::REG_MODE, {30'd0, m});
        write_reg(gfi_pkg::REG_SIZE_X, {21'd0, sx});
        write_reg(gfi_pkg::REG_SIZE_Y, {21'd0, sy});
        write_reg(gfi_pkg::REG_SIZE_Z, {21'd0, sz});
        write_reg(gfi_pkg::REG_ORIGIN_X, ox);
        write_reg(gfi_pkg::REG_ORIGIN_Y, oy);
        write_reg(gfi_pkg::REG_ORIGIN_Z, oz);
        write_reg(gfi_pkg::REG_INV_SPACING, inv);
        n_phases++;
    endtask

    function automatic logic [31:0] point_near(logic [31:0] org, logic [10:0] sz);
        longint span, off;
        if ($urandom_range(0, 9) < 3 || g_inv == 0) return $urandom;
        span = longint'(axis_nodes(sz) + 2) << 16;
        off = longint'($urandom_range(0, span[31:0])) - 65536;
        off = (off * 65536) / longint'(g_inv);
        return org + off[31:0];
    endfunction

    typedef struct {
        gfi_pkg::t_cmd cmd;
        logic [15:0] idx;
        logic [31:0] val;
        logic [31:0] px, py, pz;
        bit          typed;
        logic [31:0] pot;
        bit          sat;
    } t_row;

    t_row script [] = '{
        '{gfi_pkg::CMD_QUERY, 16'd0, 32'd0, 32'h0001_8000, 32'h0, 32'h0, 1'b1, 32'd0, 1'b0},
        '{gfi_pkg::CMD_LOAD, 16'd0, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 1'b0, 32'd0, 1'b0},
        '{gfi_pkg::CMD_LOAD, 16'd1, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
          32'hFFFF_FFFF, 1'b0, 32'd0, 1'b0},
        '{gfi_pkg::CMD_LOAD, 16'd2, 32'h0000_0000, 32'h0, 32'h0, 32'h0, 1'b0, 32'd0, 1'b0},
        '{gfi_pkg::CMD_LOAD, 16'd3, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 1'b0, 32'd0, 1'b0},
        '{gfi_pkg::CMD_LOAD, 16'd4, 32'h0002_0000, 32'h0, 32'h0, 32'h0, 1'b0, 32'd0, 1'b0},
        '{gfi_pkg::CMD_LOAD, 16'd5, 32'hFFFE_8000, 32'h0, 32'h0, 32'h0, 1'b0, 32'd0, 1'b0},
        '{gfi_pkg::CMD_LOAD, 16'd6, 32'h0010_0000, 32'h0, 32'h0, 32'h0, 1'b0, 32'd0, 1'b0},
        '{gfi_pkg::CMD_LOAD, 16'd7, 32'h1234_5678, 32'h0, 32'h0, 32'h0, 1'b0, 32'd0, 1'b0},
        '{gfi_pkg::CMD_LOAD, 16'hFFFF, 32'hA5A5_5A5A, 32'h0, 32'h0, 32'h0, 1'b0, 32'd0, 1'b0},
        '{gfi_pkg::CMD_QUERY, 16'd0, 32'd0, 32'h0, 32'h0, 32'h0, 1'b1, 32'h7FFF_FFFF, 1'b0},
        '{gfi_pkg::CMD_QUERY, 16'd0, 32'd0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
          1'b1, 32'h1234_5678, 1'b0},
        '{gfi_pkg::CMD_QUERY, 16'd0, 32'd0, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000,
          1'b0, 32'd0, 1'b0},
        '{gfi_pkg::CMD_QUERY, 16'd0, 32'd0, 32'hFFFF_0000, 32'h0, 32'h0, 1'b0, 32'd0, 1'b0},
        '{gfi_pkg::CMD_QUERY, 16'd0, 32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
          1'b0, 32'd0, 1'b0},
        '{gfi_pkg::CMD_QUERY, 16'd0, 32'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
          1'b0, 32'd0, 1'b0},
        '{gfi_pkg::CMD_QUERY, 16'd0, 32'd0, 32'h0003_4000, 32'hFFFE_C000, 32'h0000_0001,
          1'b0, 32'd0, 1'b0}
    };

    initial begin
        gfi_pkg::t_item   it;
        gfi_pkg::t_result res;
        logic [31:0] invs [4];
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (script[r]) begin
            it = '0;
            it.command = script[r].cmd;
            it.node_index = script[r].idx;
            it.node_value = script[r].val;
            it.pos_x = script[r].px;
            it.pos_y = script[r].py;
            it.pos_z = script[r].pz;
            res.potential = script[r].pot;
            res.saturated = script[r].sat;
            send_item(it, script[r].typed, res);
        end

        invs = '{32'd65536, 32'd32768, 32'd131072, 32'd0};
        for (int p = 0; p < 9; p++) begin
            case (p)
                0: set_grid(gfi_pkg::MODE_1D, 11'd1024, 11'd2, 11'd2, 32'h8000_0000, 32'h0,
                            32'h0, 32'hFFFF_FFFF);
                1: set_grid(gfi_pkg::MODE_2D, 11'd3, 11'd5, 11'd2, 32'h7FFF_FFFF,
                            32'hFFFF_0000, 32'h0, 32'd65536);
                2: set_grid(MODE_3D, 11'd3, 11'd4, 11'd2, 32'h0001_0000, 32'hFFFE_8000,
                            32'h0003_0000, 32'h0002_0000);
                3: set_grid(MODE_3X, 11'd2, 11'd2, 11'd3, 32'h0, 32'h0, 32'h8000_0000,
                            32'd1);
                4: set_grid(MODE_3D, 11'd0, 11'd2047, 11'd1024, 32'h0, 32'h0, 32'h0,
                            32'd0);
                5: set_grid(gfi_pkg::MODE_2D, 11'd1024, 11'd1024, 11'd2, 32'hFFFF_0000,
                            32'h0001_0000, 32'h0, 32'd65536);
                default: set_grid(2'($urandom_range(0, 3)), 11'($urandom_range(2, 12)),
                                  11'($urandom_range(2, 12)), 11'($urandom_range(2, 12)),
                                  $urandom_range(0, 32'h7_FFFF) - 32'h4_0000,
                                  $urandom_range(0, 32'h7_FFFF) - 32'h4_0000,
                                  $urandom_range(0, 32'h7_FFFF) - 32'h4_0000,
                                  ($urandom_range(0, 3) == 3) ? $urandom
                                                              : invs[$urandom_range(0, 2)]);
            endcase
            calm = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < RND_ITEMS; n++) begin
                if (n == RND_ITEMS / 2) calm = ~calm;
                if ($urandom_range(0, 9) == 0) begin
                    load_node(16'($urandom), node_sample());
                end else begin
                    it = '0;
                    it.command = gfi_pkg::CMD_QUERY;
                    it.node_index = 16'($urandom);
                    it.node_value = $urandom;
                    it.pos_x = point_near(g_ox, g_sx);
                    it.pos_y = point_near(g_oy, g_sy);
                    it.pos_z = point_near(g_oz, g_sz);
                    query_point(it);
                end
            end
        end

        drain();
        $display("Ran %0d node loads and %0d queries over %0d grid settings.",
                 n_loads, n_queries, n_phases);
        $display("%0d results came back clipped to the 32-bit range.", n_sat);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches seen.", errors);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
